FILE: src/fbc_pkg.sv
// Shared types and constants for the frustum box classifier.
`timescale 1ns / 1ps
package fbc_pkg;

  localparam int unsigned FBC_NUM_PLANES = 6;
  localparam int unsigned FBC_NUM_AXES   = 3;

  localparam int unsigned FBC_COORD_W = 16;  // Q8.7 box coordinate
  localparam int unsigned FBC_NORM_W  = 12;  // Q2.9 normal component
  localparam int unsigned FBC_DIST_W  = 28;  // plane distance at product scale
  localparam int unsigned FBC_PROD_W  = 28;  // 12 x 16 signed product
  localparam int unsigned FBC_PAIR_W  = 29;  // sum of two products
  localparam int unsigned FBC_SUM_W   = 30;  // three products plus distance

  // Register stages inside fbc_plane_eval
  localparam int unsigned FBC_PLANE_STAGES = 3;

  localparam int unsigned FBC_IDX_W  = 3;
  localparam int unsigned FBC_DATA_W = 64;

  // Register indices on the configuration port
  localparam logic [FBC_IDX_W-1:0] FBC_REG_NEAR   = 3'd0;
  localparam logic [FBC_IDX_W-1:0] FBC_REG_FAR    = 3'd1;
  localparam logic [FBC_IDX_W-1:0] FBC_REG_LEFT   = 3'd2;
  localparam logic [FBC_IDX_W-1:0] FBC_REG_RIGHT  = 3'd3;
  localparam logic [FBC_IDX_W-1:0] FBC_REG_BOTTOM = 3'd4;
  localparam logic [FBC_IDX_W-1:0] FBC_REG_TOP    = 3'd5;

  typedef enum logic [1:0] {
    VERDICT_OUTSIDE = 2'd0,
    VERDICT_PARTIAL = 2'd1,
    VERDICT_INSIDE  = 2'd2
  } verdict_e;

  // Packed exactly as the 64-bit plane register
  typedef struct packed {
    logic signed [FBC_DIST_W-1:0] d;
    logic signed [FBC_NORM_W-1:0] nz;
    logic signed [FBC_NORM_W-1:0] ny;
    logic signed [FBC_NORM_W-1:0] nx;
  } fbc_plane_t;

  typedef struct packed {
    logic signed [FBC_COORD_W-1:0] z;
    logic signed [FBC_COORD_W-1:0] y;
    logic signed [FBC_COORD_W-1:0] x;
  } fbc_point_t;

  // Per-plane outcome, registered at the end of the plane pipeline
  typedef struct packed {
    logic none_pos;  // no corner strictly positive
    logic all_pos;   // every corner strictly positive
  } fbc_flags_t;

endpackage

FILE: src/fbc_plane_regs.sv
// Plane coefficient registers written through the configuration port.
`timescale 1ns / 1ps
module fbc_plane_regs
  import fbc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [FBC_IDX_W-1:0]  cfg_index_i,
  input  logic [FBC_DATA_W-1:0] cfg_data_i,
  output fbc_plane_t            planes_o [FBC_NUM_PLANES]
);

  fbc_plane_t planes_q [FBC_NUM_PLANES];

  // Indices above the last plane are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FBC_NUM_PLANES; i++) begin
        planes_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < FBC_NUM_PLANES; i++) begin
        if (cfg_we_i && (cfg_index_i == FBC_IDX_W'(i))) begin
          planes_q[i] <= fbc_plane_t'(cfg_data_i);
        end
      end
    end
  end

  assign planes_o = planes_q;

endmodule

FILE: src/fbc_plane_eval.sv
// Three-stage evaluation of one plane against the eight box corners.
`timescale 1ns / 1ps
module fbc_plane_eval
  import fbc_pkg::*;
(
  input  logic       clk_i,
  input  fbc_plane_t plane_i,
  input  fbc_point_t corner_a_i,
  input  fbc_point_t corner_b_i,
  output fbc_flags_t flags_o
);

  // The largest and smallest of n.p over the eight corners are the sums of
  // the per-axis extremes, so two sums decide "none" and "all" positive.

  logic signed [FBC_NORM_W-1:0]  norm  [FBC_NUM_AXES];
  logic signed [FBC_COORD_W-1:0] coord_a [FBC_NUM_AXES];
  logic signed [FBC_COORD_W-1:0] coord_b [FBC_NUM_AXES];

  assign norm[0]    = plane_i.nx;
  assign norm[1]    = plane_i.ny;
  assign norm[2]    = plane_i.nz;
  assign coord_a[0] = corner_a_i.x;
  assign coord_a[1] = corner_a_i.y;
  assign coord_a[2] = corner_a_i.z;
  assign coord_b[0] = corner_b_i.x;
  assign coord_b[1] = corner_b_i.y;
  assign coord_b[2] = corner_b_i.z;

  // Stage 1: products
  logic signed [FBC_PROD_W-1:0] prod_a_d [FBC_NUM_AXES];
  logic signed [FBC_PROD_W-1:0] prod_b_d [FBC_NUM_AXES];
  logic signed [FBC_PROD_W-1:0] prod_a_q [FBC_NUM_AXES];
  logic signed [FBC_PROD_W-1:0] prod_b_q [FBC_NUM_AXES];

  always_comb begin
    for (int i = 0; i < FBC_NUM_AXES; i++) begin
      prod_a_d[i] = FBC_PROD_W'(norm[i]) * FBC_PROD_W'(coord_a[i]);
      prod_b_d[i] = FBC_PROD_W'(norm[i]) * FBC_PROD_W'(coord_b[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
  end

  // Stage 2: per-axis extremes, x and y summed
  logic signed [FBC_PROD_W-1:0] hi [FBC_NUM_AXES];
  logic signed [FBC_PROD_W-1:0] lo [FBC_NUM_AXES];
  logic signed [FBC_PAIR_W-1:0] hi_xy_d, lo_xy_d, hi_xy_q, lo_xy_q;
  logic signed [FBC_PROD_W-1:0] hi_z_q, lo_z_q;

  always_comb begin
    for (int i = 0; i < FBC_NUM_AXES; i++) begin
      if (prod_a_q[i] > prod_b_q[i]) begin
        hi[i] = prod_a_q[i];
        lo[i] = prod_b_q[i];
      end else begin
        hi[i] = prod_b_q[i];
        lo[i] = prod_a_q[i];
      end
    end
    hi_xy_d = FBC_PAIR_W'(hi[0]) + FBC_PAIR_W'(hi[1]);
    lo_xy_d = FBC_PAIR_W'(lo[0]) + FBC_PAIR_W'(lo[1]);
  end

  always_ff @(posedge clk_i) begin
    hi_xy_q <= hi_xy_d;
    lo_xy_q <= lo_xy_d;
    hi_z_q  <= hi[2];
    lo_z_q  <= lo[2];
  end

  // Stage 3: add z and distance, sign test
  logic signed [FBC_SUM_W-1:0] max_s, min_s;
  fbc_flags_t                  flags_d, flags_q;

  always_comb begin
    max_s = FBC_SUM_W'(hi_xy_q) + FBC_SUM_W'(hi_z_q) + FBC_SUM_W'(plane_i.d);
    min_s = FBC_SUM_W'(lo_xy_q) + FBC_SUM_W'(lo_z_q) + FBC_SUM_W'(plane_i.d);
    flags_d.none_pos = !(max_s > 0);
    flags_d.all_pos  = (min_s > 0);
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  assign flags_o = flags_q;

endmodule

FILE: src/frustum_box_classify_core.sv
// Top level: frustum culling of an axis-aligned box against six planes.
//
//   channel   signals                                  direction  accepted when
//   command   start_i, busy_o, corner_{a,b}_{x,y,z}_i  in         start_i & !busy_o
//   result    result_valid_o, verdict_o                out        every strobe cycle
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i,   in         cfg_valid_i & cfg_ready_o
//             cfg_data_i
//
// One box per cycle; busy_o never rises. A result strobes once its command
// transaction has passed the multiply, extremes, plane-sum and verdict registers.
// Reset clears the planes (every box then reads outside) and the valid pipe.
// No stall anywhere: the result must be taken in its strobe cycle.
// Planes are read live, so write them only while no box is in flight.
`timescale 1ns / 1ps
module frustum_box_classify_core
  import fbc_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [FBC_COORD_W-1:0] corner_a_x_i,
  input  logic signed [FBC_COORD_W-1:0] corner_a_y_i,
  input  logic signed [FBC_COORD_W-1:0] corner_a_z_i,
  input  logic signed [FBC_COORD_W-1:0] corner_b_x_i,
  input  logic signed [FBC_COORD_W-1:0] corner_b_y_i,
  input  logic signed [FBC_COORD_W-1:0] corner_b_z_i,
  output logic                          result_valid_o,
  output logic [1:0]                    verdict_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [FBC_IDX_W-1:0]          cfg_index_i,
  input  logic [FBC_DATA_W-1:0]         cfg_data_i
);

  logic       accept;
  logic       cfg_we;
  fbc_plane_t planes [FBC_NUM_PLANES];
  fbc_point_t corner_a, corner_b;
  fbc_flags_t flags [FBC_NUM_PLANES];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign corner_a = '{x: corner_a_x_i, y: corner_a_y_i, z: corner_a_z_i};
  assign corner_b = '{x: corner_b_x_i, y: corner_b_y_i, z: corner_b_z_i};

  fbc_plane_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .planes_o    (planes)
  );

  for (genvar p = 0; p < FBC_NUM_PLANES; p++) begin : g_plane
    fbc_plane_eval u_eval (
      .clk_i      (clk_i),
      .plane_i    (planes[p]),
      .corner_a_i (corner_a),
      .corner_b_i (corner_b),
      .flags_o    (flags[p])
    );
  end

  // Valid bits travelling alongside the plane pipeline
  logic [FBC_PLANE_STAGES-1:0] valid_d, valid_q;
  logic                        result_valid_q;
  verdict_e                    verdict_d, verdict_q;
  logic                        any_none, all_full;

  assign valid_d = {valid_q[FBC_PLANE_STAGES-2:0], accept};

  always_comb begin
    any_none = 1'b0;
    all_full = 1'b1;
    for (int p = 0; p < FBC_NUM_PLANES; p++) begin
      any_none = any_none | flags[p].none_pos;
      all_full = all_full & flags[p].all_pos;
    end
    if (any_none) begin
      verdict_d = VERDICT_OUTSIDE;
    end else if (all_full) begin
      verdict_d = VERDICT_INSIDE;
    end else begin
      verdict_d = VERDICT_PARTIAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      valid_q        <= valid_d;
      result_valid_q <= valid_q[FBC_PLANE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign result_valid_o = result_valid_q;
  assign verdict_o      = verdict_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 result_valid_o)
    else $error("command transaction without result four cycles later");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(valid_q[FBC_PLANE_STAGES-1]))
    else $error("result strobe without a box in the last plane stage");

  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[FBC_PLANE_STAGES-1] && all_full && !any_none)
      |=> (verdict_o == VERDICT_INSIDE))
    else $error("all planes full but verdict not inside");

  a_cfg_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we && (cfg_index_i == FBC_REG_NEAR))
      |=> (planes[0] == fbc_plane_t'($past(cfg_data_i))))
    else $error("near plane write not taken");
`endif

endmodule
